[hw/rtl/name_keyed_directory_table_macros.svh]
// ----------------------------------------------------------------------------
// name_keyed_directory_table_macros
// Assertion macros for the directory table. The bodies refer to clk and
// arst_n of the including module.
// ----------------------------------------------------------------------------
`ifndef NAME_KEYED_DIRECTORY_TABLE_MACROS_SVH
`define NAME_KEYED_DIRECTORY_TABLE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define NDT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent
`define NDT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/ndt_pkg.sv]
// ----------------------------------------------------------------------------
// ndt_pkg
// Shared types, constants and helpers of the name-keyed directory table.
// ----------------------------------------------------------------------------
package ndt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int NAME_BYTES  = 8;

	localparam int IDX_W     = $clog2(TABLE_DEPTH);
	localparam int CNT_W     = IDX_W + 1;
	localparam int KEY_W     = 64;
	localparam int KEY_BYTES = KEY_W / 8;
	localparam int SECTOR_W  = 16;
	localparam int OP_W      = 2;
	localparam int STATUS_W  = 2;
	localparam int OUT_IDX_W = 6;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [OP_W-1:0] {
		OP_FIND   = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_INIT   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_DUPLICATE = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_SECTOR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PARENT_SECTOR  = 1'd1;

	typedef enum logic [2:0] {
		S_BOOT0,
		S_BOOT1,
		S_IDLE,
		S_WALK,
		S_COMMIT,
		S_INIT0,
		S_INIT1,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]    name;
		logic [SECTOR_W-1:0] sector;
		logic                dir;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch the transaction, restart the walk
		logic walk_en;   // advance the table walk
		logic commit;    // apply add or remove
		logic init_wr0;  // rebuild dot entry, reset valid bits to the two dot entries
		logic init_wr1;  // rebuild dot-dot entry
		logic boot;      // use zero sectors for the rebuild
		logic res_load;  // load the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic walk_done;
		logic res_free;
	} sts_t;

	// keep bytes up to the first zero byte or NAME_BYTES, whichever comes first
	function automatic logic [KEY_W-1:0] normalize_name(input logic [KEY_W-1:0] key);
		logic [KEY_W-1:0] kept;
		logic             alive;
		kept  = '0;
		alive = 1'b1;
		for (int b = 0; b < KEY_BYTES; b++) begin
			if (b >= NAME_BYTES || key[8*b +: 8] == 8'h00)
				alive = 1'b0;
			if (alive)
				kept[8*b +: 8] = key[8*b +: 8];
		end
		return kept;
	endfunction

	localparam logic [KEY_W-1:0] NAME_DOT    = normalize_name(64'h2E);
	localparam logic [KEY_W-1:0] NAME_DOTDOT = normalize_name(64'h2E2E);

	localparam logic [TABLE_DEPTH-1:0] VALID_INIT = TABLE_DEPTH'(2'b11);

endpackage

[hw/rtl/name_keyed_directory_table.sv]
// ----------------------------------------------------------------------------
// name_keyed_directory_table
// Fixed-depth directory of named entries with find, add, remove and init.
// ----------------------------------------------------------------------------
// One transaction at a time. Find, add and remove read the entry memory one
// entry per cycle over all 64 entries through a read register, then pass
// through a commit state and a result state. Init rewrites the dot and
// dot-dot entries through the single memory write port. After reset the
// same rebuild runs with zero sectors before the first transaction is
// accepted. A waiting result sits in the output register and does not
// block acceptance of the next transaction. Names are compared after cutting
// at the first zero byte; the lowest matching or free entry wins.
`include "name_keyed_directory_table_macros.svh"

module name_keyed_directory_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ndt_pkg::OP_W-1:0]          operation,
	input  logic [ndt_pkg::KEY_W-1:0]         name_key,
	input  logic [ndt_pkg::SECTOR_W-1:0]      sector,
	input  logic                              is_dir,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ndt_pkg::STATUS_W-1:0]      status,
	output logic [ndt_pkg::OUT_IDX_W-1:0]     entry_index,
	output logic [ndt_pkg::SECTOR_W-1:0]      found_sector,
	output logic                              found_is_dir,
	input  logic                              cfg_we,
	input  logic [ndt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ndt_pkg::SECTOR_W-1:0]      cfg_data
);

	ndt_pkg::cmd_t cmd;
	ndt_pkg::sts_t sts;

	ndt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_ready  (in_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ndt_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (operation),
		.name_key     (name_key),
		.sector       (sector),
		.is_dir       (is_dir),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.status       (status),
		.entry_index  (entry_index),
		.found_sector (found_sector),
		.found_is_dir (found_is_dir)
	);

	`NDT_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "accepted twice in a row")
	`NDT_ASSERT_SAME(a_res_slot_free, cmd.res_load, sts.res_free, "result overwrote a pending one")
	`NDT_ASSERT_NEXT(a_commit_after_walk, cmd.walk_en && sts.walk_done, cmd.commit, "no commit")

endmodule

[hw/rtl/ndt_ctrl.sv]
// ----------------------------------------------------------------------------
// ndt_ctrl
// Sequencer of the directory table: rebuild after reset, table walk,
// commit and result hand-off.
// ----------------------------------------------------------------------------
module ndt_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [ndt_pkg::OP_W-1:0]       operation,
	output logic                           in_ready,
	input  ndt_pkg::sts_t                  sts,
	output ndt_pkg::cmd_t                  cmd
);

	ndt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ndt_pkg::S_BOOT0;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ndt_pkg::S_BOOT0: begin
				cmd.init_wr0 = 1'b1;
				cmd.boot     = 1'b1;
				state_d      = ndt_pkg::S_BOOT1;
			end
			ndt_pkg::S_BOOT1: begin
				cmd.init_wr1 = 1'b1;
				cmd.boot     = 1'b1;
				state_d      = ndt_pkg::S_IDLE;
			end
			ndt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (operation == ndt_pkg::OP_INIT)
						state_d = ndt_pkg::S_INIT0;
					else
						state_d = ndt_pkg::S_WALK;
				end
			end
			ndt_pkg::S_WALK: begin
				cmd.walk_en = 1'b1;
				if (sts.walk_done)
					state_d = ndt_pkg::S_COMMIT;
			end
			ndt_pkg::S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ndt_pkg::S_RESP;
			end
			ndt_pkg::S_INIT0: begin
				cmd.init_wr0 = 1'b1;
				state_d      = ndt_pkg::S_INIT1;
			end
			ndt_pkg::S_INIT1: begin
				cmd.init_wr1 = 1'b1;
				state_d      = ndt_pkg::S_RESP;
			end
			ndt_pkg::S_RESP: begin
				// hold until the output register can take the result
				if (sts.res_free) begin
					cmd.res_load = 1'b1;
					state_d      = ndt_pkg::S_IDLE;
				end
			end
			default: state_d = ndt_pkg::S_IDLE;
		endcase
	end

endmodule

[hw/rtl/ndt_datapath.sv]
// ----------------------------------------------------------------------------
// ndt_datapath
// Entry memory, valid bits, walk counter with match and free-slot trackers,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module ndt_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ndt_pkg::cmd_t                     cmd,
	output ndt_pkg::sts_t                     sts,
	input  logic [ndt_pkg::OP_W-1:0]          operation,
	input  logic [ndt_pkg::KEY_W-1:0]         name_key,
	input  logic [ndt_pkg::SECTOR_W-1:0]      sector,
	input  logic                              is_dir,
	input  logic                              cfg_we,
	input  logic [ndt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ndt_pkg::SECTOR_W-1:0]      cfg_data,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [ndt_pkg::STATUS_W-1:0]      status,
	output logic [ndt_pkg::OUT_IDX_W-1:0]     entry_index,
	output logic [ndt_pkg::SECTOR_W-1:0]      found_sector,
	output logic                              found_is_dir
);

	// configuration
	logic [ndt_pkg::SECTOR_W-1:0] cur_sector_q, par_sector_q;

	// latched transaction
	ndt_pkg::op_t                 op_q;
	logic [ndt_pkg::KEY_W-1:0]    key_q;
	logic [ndt_pkg::SECTOR_W-1:0] sec_q;
	logic                         dir_q;

	// table
	ndt_pkg::entry_t                 ram_q [ndt_pkg::TABLE_DEPTH];
	logic [ndt_pkg::TABLE_DEPTH-1:0] valid_q;
	logic                            mem_we;
	logic [ndt_pkg::IDX_W-1:0]       mem_waddr;
	ndt_pkg::entry_t                 mem_wdata;

	// walk
	logic [ndt_pkg::CNT_W-1:0]    cnt_q;
	logic                         issue;
	ndt_pkg::entry_t              rd_s1;
	logic                         v_s1, vbit_s1;
	logic [ndt_pkg::IDX_W-1:0]    idx_s1;
	logic                         match;
	logic                         hit_q, free_q;
	logic [ndt_pkg::IDX_W-1:0]    hit_idx_q, free_idx_q;
	logic [ndt_pkg::SECTOR_W-1:0] hit_sec_q;
	logic                         hit_dir_q;
	logic                         add_wr, rem_clr;

	// result
	logic                          out_valid_q;
	ndt_pkg::status_t              res_status, status_q;
	logic [ndt_pkg::OUT_IDX_W-1:0] res_idx, idx_q;
	logic [ndt_pkg::SECTOR_W-1:0]  res_sec, fsec_q;
	logic                          res_dir, fdir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_sector_q <= '0;
			par_sector_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ndt_pkg::REG_CURRENT_SECTOR: cur_sector_q <= cfg_data;
				ndt_pkg::REG_PARENT_SECTOR:  par_sector_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= ndt_pkg::op_t'(operation);
			key_q <= ndt_pkg::normalize_name(name_key);
			sec_q <= sector;
			dir_q <= is_dir;
		end
	end

	assign add_wr  = cmd.commit && op_q == ndt_pkg::OP_ADD && !hit_q && free_q;
	assign rem_clr = cmd.commit && op_q == ndt_pkg::OP_REMOVE && hit_q;

	always_comb begin
		mem_we    = add_wr;
		mem_waddr = free_idx_q;
		mem_wdata = '{name: key_q, sector: sec_q, dir: dir_q};
		if (cmd.init_wr0) begin
			mem_we    = 1'b1;
			mem_waddr = ndt_pkg::IDX_W'(0);
			mem_wdata = '{name: ndt_pkg::NAME_DOT,
				sector: cmd.boot ? '0 : cur_sector_q, dir: 1'b1};
		end else if (cmd.init_wr1) begin
			mem_we    = 1'b1;
			mem_waddr = ndt_pkg::IDX_W'(1);
			mem_wdata = '{name: ndt_pkg::NAME_DOTDOT,
				sector: cmd.boot ? '0 : par_sector_q, dir: 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			ram_q[mem_waddr] <= mem_wdata;
		rd_s1 <= ram_q[cnt_q[ndt_pkg::IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= ndt_pkg::VALID_INIT;
		end else if (cmd.init_wr0) begin
			valid_q <= ndt_pkg::VALID_INIT;
		end else if (add_wr) begin
			valid_q[free_idx_q] <= 1'b1;
		end else if (rem_clr) begin
			valid_q[hit_idx_q] <= 1'b0;
		end
	end

	assign issue = cnt_q < ndt_pkg::CNT_W'(ndt_pkg::TABLE_DEPTH);
	assign match = vbit_s1 && rd_s1.name == key_q;

	// one entry read per cycle; compare in the cycle after the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			v_s1       <= 1'b0;
			vbit_s1    <= 1'b0;
			idx_s1     <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			hit_idx_q  <= '0;
			free_idx_q <= '0;
			hit_sec_q  <= '0;
			hit_dir_q  <= 1'b0;
		end else if (cmd.load) begin
			cnt_q  <= '0;
			v_s1   <= 1'b0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.walk_en) begin
			v_s1    <= issue;
			vbit_s1 <= valid_q[cnt_q[ndt_pkg::IDX_W-1:0]];
			idx_s1  <= cnt_q[ndt_pkg::IDX_W-1:0];
			if (issue)
				cnt_q <= cnt_q + 1'b1;
			if (v_s1 && match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
				hit_sec_q <= rd_s1.sector;
				hit_dir_q <= rd_s1.dir;
			end
			if (v_s1 && !vbit_s1 && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
		end
	end

	always_comb begin
		res_status = ndt_pkg::ST_OK;
		res_idx    = '0;
		res_sec    = '0;
		res_dir    = 1'b0;
		unique case (op_q)
			ndt_pkg::OP_FIND: begin
				if (hit_q) begin
					res_idx = ndt_pkg::OUT_IDX_W'(hit_idx_q);
					res_sec = hit_sec_q;
					res_dir = hit_dir_q;
				end else begin
					res_status = ndt_pkg::ST_NOT_FOUND;
				end
			end
			ndt_pkg::OP_ADD: begin
				if (hit_q) begin
					res_status = ndt_pkg::ST_DUPLICATE;
					res_idx    = ndt_pkg::OUT_IDX_W'(hit_idx_q);
				end else if (free_q) begin
					res_idx = ndt_pkg::OUT_IDX_W'(free_idx_q);
				end else begin
					res_status = ndt_pkg::ST_FULL;
				end
			end
			ndt_pkg::OP_REMOVE: begin
				if (hit_q)
					res_idx = ndt_pkg::OUT_IDX_W'(hit_idx_q);
				else
					res_status = ndt_pkg::ST_NOT_FOUND;
			end
			ndt_pkg::OP_INIT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.res_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= res_status;
			idx_q    <= res_idx;
			fsec_q   <= res_sec;
			fdir_q   <= res_dir;
		end
	end

	assign sts.walk_done = !issue && !v_s1;
	assign sts.res_free  = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign entry_index  = idx_q;
	assign found_sector = fsec_q;
	assign found_is_dir = fdir_q;

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the name-keyed directory table. A model of the
// table predicts status, index, sector and flag for every accepted
// transaction. Directed checks cover reset contents, register-driven init,
// name cutting, dot removal and a full table. A long output stall check and
// random phases follow, with random gaps on both sides in all but every fourth phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

	localparam int DRAIN_CYCLES = 80;    // a little over one table walk
	localparam int CYCLE_LIMIT  = 500000;
	localparam int POOL_N       = 24;

	typedef struct packed {
		ndt_pkg::status_t                  st;
		logic [ndt_pkg::OUT_IDX_W-1:0]     idx;
		logic [ndt_pkg::SECTOR_W-1:0]      sec;
		logic                              dir;
	} dir_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [ndt_pkg::OP_W-1:0]      operation;
	logic [ndt_pkg::KEY_W-1:0]     name_key;
	logic [ndt_pkg::SECTOR_W-1:0]  sector;
	logic                          is_dir;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [ndt_pkg::STATUS_W-1:0]  status;
	logic [ndt_pkg::OUT_IDX_W-1:0] entry_index;
	logic [ndt_pkg::SECTOR_W-1:0]  found_sector;
	logic                          found_is_dir;
	logic                          cfg_we;
	logic [ndt_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ndt_pkg::SECTOR_W-1:0]  cfg_data;

	// table model
	logic                         tbl_valid [ndt_pkg::TABLE_DEPTH];
	logic [ndt_pkg::KEY_W-1:0]    tbl_name [ndt_pkg::TABLE_DEPTH];
	logic [ndt_pkg::SECTOR_W-1:0] tbl_sector [ndt_pkg::TABLE_DEPTH];
	logic                         tbl_dir [ndt_pkg::TABLE_DEPTH];
	logic [ndt_pkg::SECTOR_W-1:0] cur_sector_reg;
	logic [ndt_pkg::SECTOR_W-1:0] par_sector_reg;

	dir_result_t pending_results [$];
	dir_result_t want;
	logic [ndt_pkg::KEY_W-1:0] name_pool [POOL_N];

	int  errors = 0;
	int  cycles = 0;
	int  rx_wait = 0;
	int  hold_off = 0;
	logic idle_on = 1'b1;

	name_keyed_directory_table u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.name_key     (name_key),
		.sector       (sector),
		.is_dir       (is_dir),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.entry_index  (entry_index),
		.found_sector (found_sector),
		.found_is_dir (found_is_dir),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic void rebuild_table();
		for (int i = 0; i < ndt_pkg::TABLE_DEPTH; i++) begin
			tbl_valid[i]  = 1'b0;
			tbl_name[i]   = '0;
			tbl_sector[i] = '0;
			tbl_dir[i]    = 1'b0;
		end
		tbl_valid[0] = 1'b1; tbl_name[0] = 64'h2E;   tbl_sector[0] = cur_sector_reg; tbl_dir[0] = 1'b1;
		tbl_valid[1] = 1'b1; tbl_name[1] = 64'h2E2E; tbl_sector[1] = par_sector_reg; tbl_dir[1] = 1'b1;
	endfunction

	// applies one transaction to the model and returns the expected response
	function automatic dir_result_t predict_op(ndt_pkg::op_t op,
			logic [ndt_pkg::KEY_W-1:0] key, logic [ndt_pkg::SECTOR_W-1:0] sec, logic dir);
		dir_result_t r;
		logic [ndt_pkg::KEY_W-1:0] nk;
		int len;
		int hit;
		int slot;
		r.st  = ndt_pkg::ST_OK;
		r.idx = '0;
		r.sec = '0;
		r.dir = 1'b0;
		len = 0;
		while (len < ndt_pkg::NAME_BYTES && key[8*len +: 8] != 8'h00)
			len++;
		nk = (len == ndt_pkg::KEY_BYTES) ? key : key & ((64'd1 << (8*len)) - 64'd1);
		// walk downwards so the lowest match and the lowest free slot win
		hit  = -1;
		slot = -1;
		for (int i = ndt_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
			if (tbl_valid[i] && tbl_name[i] == nk)
				hit = i;
			if (!tbl_valid[i])
				slot = i;
		end
		case (op)
			ndt_pkg::OP_FIND: begin
				if (hit < 0) begin
					r.st = ndt_pkg::ST_NOT_FOUND;
				end else begin
					r.idx = ndt_pkg::OUT_IDX_W'(hit);
					r.sec = tbl_sector[hit];
					r.dir = tbl_dir[hit];
				end
			end
			ndt_pkg::OP_ADD: begin
				if (hit >= 0) begin
					r.st  = ndt_pkg::ST_DUPLICATE;
					r.idx = ndt_pkg::OUT_IDX_W'(hit);
				end else if (slot < 0) begin
					r.st = ndt_pkg::ST_FULL;
				end else begin
					tbl_valid[slot]  = 1'b1;
					tbl_name[slot]   = nk;
					tbl_sector[slot] = sec;
					tbl_dir[slot]    = dir;
					r.idx = ndt_pkg::OUT_IDX_W'(slot);
				end
			end
			ndt_pkg::OP_REMOVE: begin
				if (hit < 0) begin
					r.st = ndt_pkg::ST_NOT_FOUND;
				end else begin
					tbl_valid[hit] = 1'b0;
					r.idx = ndt_pkg::OUT_IDX_W'(hit);
				end
			end
			default: rebuild_table();
		endcase
		return r;
	endfunction

	// stored, stale, pooled, empty or fresh names, sometimes with junk past the end
	function automatic logic [ndt_pkg::KEY_W-1:0] pick_name(int fresh_pct);
		logic [ndt_pkg::KEY_W-1:0] key;
		int r;
		int len;
		r = $urandom_range(0, 99);
		if (r < fresh_pct)
			key = {$urandom, $urandom};
		else if (r < fresh_pct + 40)
			key = tbl_name[$urandom_range(0, ndt_pkg::TABLE_DEPTH - 1)];
		else if (r < fresh_pct + 45)
			key = '0;
		else
			key = name_pool[$urandom_range(0, POOL_N - 1)];
		if ($urandom_range(0, 3) == 0) begin
			len = 0;
			while (len < ndt_pkg::KEY_BYTES && key[8*len +: 8] != 8'h00)
				len++;
			if (len < ndt_pkg::KEY_BYTES - 1)
				key = key | ({$urandom, $urandom} << (8*(len + 1)));
		end
		return key;
	endfunction

	task automatic send_txn(ndt_pkg::op_t op, logic [ndt_pkg::KEY_W-1:0] key,
			logic [ndt_pkg::SECTOR_W-1:0] sec, logic dir);
		int gap;
		gap = idle_on ? $urandom_range(0, 14) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		name_key  <= key;
		sector    <= sec;
		is_dir    <= dir;
		do @(posedge clk); while (in_ready !== 1'b1);
		pending_results.push_back(predict_op(op, key, sec, dir));
	endtask

	// stop offering and wait for every outstanding response
	task automatic settle_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [ndt_pkg::CFG_IDX_W-1:0] idx,
			logic [ndt_pkg::SECTOR_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx == ndt_pkg::REG_CURRENT_SECTOR)
			cur_sector_reg = val;
		else
			par_sector_reg = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic report_field(string what, logic [15:0] exp_v, logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
			errors++;
		end
	endtask

	// output side: random stalls, plus a long hold-off when requested
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off--;
			out_ready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: response with no transaction outstanding, status %0h",
					$time, status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				report_field("status", 16'(want.st), 16'(status));
				report_field("entry_index", 16'(want.idx), 16'(entry_index));
				report_field("found_sector", want.sec, found_sector);
				report_field("found_is_dir", 16'(want.dir), 16'(found_is_dir));
			end
			rx_wait = idle_on ? $urandom_range(0, 14) : 0;
		end
	end

	task automatic check_reset_contents();
		send_txn(ndt_pkg::OP_FIND, 64'h2E, 16'h0000, 1'b0);
		send_txn(ndt_pkg::OP_FIND, 64'h2E2E, 16'hFFFF, 1'b1);
		// junk past terminator
		send_txn(ndt_pkg::OP_FIND, 64'hDEAD_BEEF_C0DE_002E, 16'h0000, 1'b0);
		send_txn(ndt_pkg::OP_FIND, 64'h0, 16'h0000, 1'b0);    // empty name, miss
		send_txn(ndt_pkg::OP_INIT, 64'h0, 16'h0000, 1'b0);
	endtask

	task automatic check_config_init();
		settle_idle();
		write_reg(ndt_pkg::REG_CURRENT_SECTOR, 16'hFFFF);
		write_reg(ndt_pkg::REG_PARENT_SECTOR, 16'h0000);
		send_txn(ndt_pkg::OP_INIT, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1);
		send_txn(ndt_pkg::OP_FIND, 64'h2E, 16'h0000, 1'b0);
		send_txn(ndt_pkg::OP_FIND, 64'h2E2E, 16'h0000, 1'b0);
		settle_idle();
		write_reg(ndt_pkg::REG_CURRENT_SECTOR, 16'h0000);
		write_reg(ndt_pkg::REG_PARENT_SECTOR, 16'hFFFF);
		send_txn(ndt_pkg::OP_INIT, 64'h0, 16'h0000, 1'b0);
		send_txn(ndt_pkg::OP_FIND, 64'h2E, 16'h0000, 1'b0);
		send_txn(ndt_pkg::OP_FIND, 64'h2E2E, 16'h0000, 1'b0);
	endtask

	task automatic check_name_handling();
		send_txn(ndt_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1);
		send_txn(ndt_pkg::OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 1'b0);
		send_txn(ndt_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 16'h1234, 1'b0); // duplicate
		send_txn(ndt_pkg::OP_ADD, 64'h0, 16'h0000, 1'b0);                   // empty name stored
		send_txn(ndt_pkg::OP_FIND, 64'hFFFF_FFFF_FFFF_FF00, 16'h0000, 1'b0); // empty name
		send_txn(ndt_pkg::OP_ADD, 64'h0102_0304_0506_0708, 16'h8001, 1'b1);
		send_txn(ndt_pkg::OP_ADD, 64'h5A5A_0000_0000_6261, 16'h00FF, 1'b0); // "ab" with junk
		send_txn(ndt_pkg::OP_ADD, 64'h0000_0000_0000_6261, 16'h0000, 1'b1); // same name
		send_txn(ndt_pkg::OP_REMOVE, 64'h0, 16'h0000, 1'b0);
		send_txn(ndt_pkg::OP_REMOVE, 64'h0, 16'h0000, 1'b0);                // miss
		send_txn(ndt_pkg::OP_FIND, 64'h0, 16'h0000, 1'b0);
		send_txn(ndt_pkg::OP_REMOVE, 64'h2E, 16'h0000, 1'b0);               // dot may go
		send_txn(ndt_pkg::OP_FIND, 64'h2E, 16'h0000, 1'b0);
		send_txn(ndt_pkg::OP_ADD, 64'h0000_0000_0063_6261, 16'hA5A5, 1'b1); // reuses entry 0
		send_txn(ndt_pkg::OP_FIND, 64'h0000_0000_0063_6261, 16'h0000, 1'b0);
		send_txn(ndt_pkg::OP_REMOVE, 64'h2E2E, 16'h0000, 1'b0);
	endtask

	task automatic check_table_full();
		send_txn(ndt_pkg::OP_INIT, 64'h0, 16'h0000, 1'b0);
		for (int i = 0; i < ndt_pkg::TABLE_DEPTH + 4; i++)
			send_txn(ndt_pkg::OP_ADD, {$urandom, $urandom}, 16'($urandom), 1'($urandom));
		send_txn(ndt_pkg::OP_ADD, 64'h2E2E, 16'h0000, 1'b0);   // duplicate wins over full
		send_txn(ndt_pkg::OP_FIND, tbl_name[ndt_pkg::TABLE_DEPTH - 1], 16'h0000, 1'b0);
		send_txn(ndt_pkg::OP_REMOVE, tbl_name[40], 16'h0000, 1'b0);
		send_txn(ndt_pkg::OP_ADD, 64'h0000_0000_0000_007A, 16'hFFFF, 1'b1);
		send_txn(ndt_pkg::OP_ADD, 64'h0000_0000_0000_0079, 16'h0000, 1'b0);
	endtask

	// the output stalls long enough for the table to hold a response and block input
	task automatic check_backpressure();
		settle_idle();
		idle_on = 1'b0;
		send_txn(ndt_pkg::OP_INIT, 64'h0, 16'h0000, 1'b0);
		hold_off = 400;
		for (int i = 0; i < 12; i++)
			send_txn(ndt_pkg::op_t'($urandom_range(0, 2)), pick_name(30), 16'($urandom),
				1'($urandom));
		settle_idle();
		idle_on = 1'b1;
	endtask

	task automatic run_random_phases();
		ndt_pkg::op_t op;
		int  r;
		int  init_pct;
		int  add_pct;
		int  rem_pct;
		int  fresh_pct;
		for (int p = 0; p < 10; p++) begin
			settle_idle();
			case (p)
				0: begin
					write_reg(ndt_pkg::REG_CURRENT_SECTOR, 16'hFFFF);
					write_reg(ndt_pkg::REG_PARENT_SECTOR, 16'hFFFF);
				end
				1: begin
					write_reg(ndt_pkg::REG_CURRENT_SECTOR, 16'h0000);
					write_reg(ndt_pkg::REG_PARENT_SECTOR, 16'h0000);
				end
				default: begin
					write_reg(ndt_pkg::REG_CURRENT_SECTOR, 16'($urandom));
					write_reg(ndt_pkg::REG_PARENT_SECTOR, 16'($urandom));
				end
			endcase
			idle_on = (p % 4 != 3);
			// alternate phases that fill the table and phases that empty it
			if (p % 2 == 0) begin
				init_pct = 1; add_pct = 55; rem_pct = 15; fresh_pct = 40;
			end else begin
				init_pct = 3; add_pct = 15; rem_pct = 50; fresh_pct = 10;
			end
			for (int i = 0; i < 100; i++) begin
				r = $urandom_range(0, 99);
				if (r < init_pct)
					op = ndt_pkg::OP_INIT;
				else if (r < init_pct + add_pct)
					op = ndt_pkg::OP_ADD;
				else if (r < init_pct + add_pct + rem_pct)
					op = ndt_pkg::OP_REMOVE;
				else
					op = ndt_pkg::OP_FIND;
				send_txn(op, pick_name(fresh_pct), 16'($urandom), 1'($urandom));
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		operation = '0;
		name_key  = '0;
		sector    = '0;
		is_dir    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		cur_sector_reg = '0;
		par_sector_reg = '0;
		rebuild_table();
		name_pool[0] = 64'h2E;
		name_pool[1] = 64'h2E2E;
		for (int i = 2; i < POOL_N; i++) begin
			name_pool[i] = '0;
			for (int b = 0; b <= i % ndt_pkg::KEY_BYTES; b++)
				name_pool[i][8*b +: 8] = 8'($urandom_range(1, 255));
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		check_reset_contents();
		check_config_init();
		check_name_handling();
		check_table_full();
		check_backpressure();
		run_random_phases();

		settle_idle();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
